// ===== design/dbcr_pkg.sv =====
package dbcr_pkg;

    // Access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access size codes
    localparam logic [1:0] SIZE_BYTE    = 2'd0;
    localparam logic [1:0] SIZE_WORD    = 2'd1;
    localparam logic [1:0] SIZE_LONG    = 2'd2;
    localparam logic [1:0] SIZE_ILLEGAL = 2'd3;

    // Register map (low address byte, long access)
    localparam logic [7:0] ADDR_INT_STATUS = 8'h00;
    localparam logic [7:0] ADDR_INT_MASK   = 8'h08;
    localparam logic [7:0] ADDR_SET_INT    = 8'h10;
    localparam logic [7:0] ADDR_CONFIG     = 8'h18;
    localparam logic [7:0] ADDR_CONTROL    = 8'h20;
    localparam logic [7:0] ADDR_STATUS     = 8'h28;
    localparam logic [7:0] ADDR_COMMAND    = 8'h30;
    localparam logic [7:0] ADDR_BIT_COUNT  = 8'h38;
    localparam logic [7:0] ADDR_DATA0      = 8'h80;
    localparam logic [7:0] ADDR_DATA1      = 8'h88;

    // Interrupt bits
    localparam logic [31:0] INT_REJECT = 32'h0000_0001;
    localparam logic [31:0] INT_ACCESS = 32'h0000_0004;
    localparam logic [31:0] INT_RESET  = 32'h0000_0008;

    // Control write bits
    localparam int CTL_EN_POLL_BIT  = 0;
    localparam int CTL_DIS_POLL_BIT = 1;
    localparam int CTL_XMIT_BIT     = 2;
    localparam int CTL_RESET_BIT    = 3;

    // Status byte bits
    localparam logic [7:0] ST_TIMEOUT = 8'h04;
    localparam logic [7:0] ST_RESET   = 8'h10;
    localparam logic [7:0] ST_ACCESS  = 8'h20;
    localparam logic [7:0] ST_POLL_EN = 8'h40;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  access_size;
        logic [7:0]  address;
        logic [31:0] write_data;
    } dbcr_access_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bus_error;
        logic        irq_out;
    } dbcr_result_t;

endpackage

// ===== design/dbcr_core.sv =====
module dbcr_core
    import dbcr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  dbcr_access_t acc,
    output dbcr_result_t result
);

    logic [31:0] int_status_reg;
    logic [31:0] int_mask_reg;
    logic [31:0] config_word_reg;
    logic [7:0]  status_byte_reg;
    logic [31:0] command_word_reg;
    logic [31:0] bit_count_reg;
    logic [31:0] data0_reg;
    logic [31:0] data1_reg;
    logic        irq_level_reg;

    logic [31:0] int_status_next;
    logic [31:0] int_mask_next;
    logic [31:0] config_word_next;
    logic [7:0]  status_byte_next;
    logic [31:0] command_word_next;
    logic [31:0] bit_count_next;
    logic [31:0] data0_next;
    logic [31:0] data1_next;
    logic        irq_level_next;

    logic [7:0]  dec_addr;
    logic [31:0] full;
    logic        rd_hit;
    logic        wr_hit;
    logic [31:0] rdata;
    logic        err;
    logic [7:0]  st_a;
    logic [7:0]  st_b;
    logic [7:0]  st_c;
    logic [31:0] raised;
    logic [31:0] st_clr;
    logic [31:0] st_set;

    // Register read decode; narrow reads decode on the aligned long address
    always_comb
    begin
        dec_addr = (acc.access_size == SIZE_LONG) ? acc.address : {acc.address[7:2], 2'b00};
        rd_hit   = 1'b1;
        unique case (dec_addr)
            ADDR_INT_STATUS: full = int_status_reg;
            ADDR_INT_MASK:   full = int_mask_reg;
            ADDR_CONFIG:     full = config_word_reg;
            ADDR_STATUS:     full = {24'h0, status_byte_reg};
            ADDR_COMMAND:    full = command_word_reg;
            ADDR_BIT_COUNT:  full = bit_count_reg;
            ADDR_DATA0:      full = data0_reg;
            ADDR_DATA1:      full = data1_reg;
            default:
            begin
                full   = 32'h0;
                rd_hit = 1'b0;
            end
        endcase
    end

    // Control write: reset, transmit, disable poll, enable poll, in that order
    always_comb
    begin
        raised = 32'h0;
        st_a   = status_byte_reg;
        if (acc.write_data[CTL_RESET_BIT])
        begin
            st_a   = st_a & ~ST_POLL_EN;
            raised = raised | INT_RESET;
        end
        st_b = st_a;
        if (acc.write_data[CTL_XMIT_BIT])
        begin
            if ((st_a & (ST_RESET | ST_ACCESS)) != 8'h0)
            begin
                raised = raised | INT_REJECT;
            end
            else
            begin
                st_b   = st_a | ST_TIMEOUT;
                raised = raised | INT_ACCESS;
            end
        end
        st_c = st_b;
        if (acc.write_data[CTL_DIS_POLL_BIT])
        begin
            st_c = st_b & ~ST_POLL_EN;
        end
        if (acc.write_data[CTL_EN_POLL_BIT])
        begin
            if (((st_c & (ST_RESET | ST_ACCESS)) != 8'h0) && ((st_c & ST_POLL_EN) == 8'h0))
            begin
                raised = raised | INT_REJECT;
            end
            else
            begin
                st_c = st_c | ST_POLL_EN;
            end
        end
    end

    assign st_clr = int_status_reg & ~acc.write_data;
    assign st_set = int_status_reg | acc.write_data;

    always_comb
    begin
        int_status_next   = int_status_reg;
        int_mask_next     = int_mask_reg;
        config_word_next  = config_word_reg;
        status_byte_next  = status_byte_reg;
        command_word_next = command_word_reg;
        bit_count_next    = bit_count_reg;
        data0_next        = data0_reg;
        data1_next        = data1_reg;
        irq_level_next    = irq_level_reg;
        wr_hit            = 1'b1;
        unique case (acc.address)
            ADDR_INT_STATUS:
            begin
                int_status_next = st_clr;
                if ((st_clr & int_mask_reg) == 32'h0)
                begin
                    irq_level_next = 1'b0;
                end
            end
            ADDR_INT_MASK:
            begin
                int_mask_next  = acc.write_data;
                irq_level_next = (int_status_reg & acc.write_data) != 32'h0;
            end
            ADDR_SET_INT:
            begin
                int_status_next = st_set;
                if ((st_set & int_mask_reg) != 32'h0)
                begin
                    irq_level_next = 1'b1;
                end
            end
            ADDR_CONFIG:    config_word_next  = acc.write_data;
            ADDR_CONTROL:
            begin
                status_byte_next = st_c;
                int_status_next  = int_status_reg | raised;
                if ((raised & int_mask_reg) != 32'h0)
                begin
                    irq_level_next = 1'b1;
                end
            end
            ADDR_COMMAND:   command_word_next = acc.write_data;
            ADDR_BIT_COUNT: bit_count_next    = acc.write_data;
            ADDR_DATA0:     data0_next        = acc.write_data;
            ADDR_DATA1:     data1_next        = acc.write_data;
            default:        wr_hit            = 1'b0;
        endcase
    end

    // Result: long reads return the full register, narrow reads a lane; writes and errors return zero data
    always_comb
    begin
        rdata = 32'h0;
        err   = 1'b0;
        if (acc.access_size == SIZE_ILLEGAL)
        begin
            err = 1'b1;
        end
        else if (acc.opcode == OP_WRITE)
        begin
            err = (acc.access_size != SIZE_LONG) || !wr_hit;
        end
        else if (!rd_hit)
        begin
            err = 1'b1;
        end
        else if (acc.access_size == SIZE_LONG)
        begin
            rdata = full;
        end
        else if (acc.access_size == SIZE_WORD)
        begin
            rdata = acc.address[1] ? {16'h0, full[15:0]} : {16'h0, full[31:16]};
        end
        else
        begin
            case (acc.address[1:0])
                2'd0:    rdata = {24'h0, full[31:24]};
                2'd1:    rdata = {24'h0, full[23:16]};
                2'd2:    rdata = {24'h0, full[15:8]};
                default: rdata = {24'h0, full[7:0]};
            endcase
        end
    end

    logic do_write;
    assign do_write = step && (acc.opcode == OP_WRITE) && (acc.access_size == SIZE_LONG)
                      && wr_hit;

    assign result.read_data = rdata;
    assign result.bus_error = err;
    assign result.irq_out   = do_write ? irq_level_next : irq_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_status_reg   <= 32'h0;
            int_mask_reg     <= 32'h0;
            config_word_reg  <= 32'h0;
            status_byte_reg  <= 8'h0;
            command_word_reg <= 32'h0;
            bit_count_reg    <= 32'h0;
            data0_reg        <= 32'h0;
            data1_reg        <= 32'h0;
            irq_level_reg    <= 1'b0;
        end
        else if (do_write)
        begin
            int_status_reg   <= int_status_next;
            int_mask_reg     <= int_mask_next;
            config_word_reg  <= config_word_next;
            status_byte_reg  <= status_byte_next;
            command_word_reg <= command_word_next;
            bit_count_reg    <= bit_count_next;
            data0_reg        <= data0_next;
            data1_reg        <= data1_next;
            irq_level_reg    <= irq_level_next;
        end
    end

endmodule

// ===== design/desktop_bus_controller_registers_unit.sv =====
// Pipeline: an accepted access is held in the access register, then decoded
//   and committed as it moves into the result register on the output port.
// Throughput: 1 access per cycle while the output is not stalled; the register
//   file decodes and updates between the access register and the result register.
// Reset (rst_n low, asynchronous): both stages empty, all register-file
//   registers zero, interrupt level cleared.
module desktop_bus_controller_registers_unit
    import dbcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [1:0]  access_size,
    input  logic [7:0]  address,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        bus_error,
    output logic        irq_out
);

    // Access stage: holds one accepted access until the result stage takes it
    logic         acc_valid_reg;
    dbcr_access_t acc_reg;

    // Result stage: holds one finished result until the consumer takes it
    logic         res_valid_reg;
    dbcr_result_t res_reg;

    dbcr_result_t core_result;
    logic         advance;
    logic         step;

    // Advance when the result stage is empty or its result leaves this cycle
    assign advance  = !res_valid_reg || !out_stall;
    // Hold the producer only while a full access stage cannot advance
    assign in_stall = acc_valid_reg && !advance;
    // Commit the access into the register file as it moves to the result stage
    assign step     = acc_valid_reg && advance;

    dbcr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .acc    (acc_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // Take a new transfer whenever the access stage is free or emptying
            if (!in_stall)
            begin
                acc_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= acc_valid_reg;
            end
        end
    end

    // Payload registers; no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            acc_reg.opcode      <= opcode;
            acc_reg.access_size <= access_size;
            acc_reg.address     <= address;
            acc_reg.write_data  <= write_data;
        end
        if (step)
        begin
            res_reg <= core_result;
        end
    end

    assign out_valid = res_valid_reg;
    assign read_data = res_reg.read_data;
    assign bus_error = res_reg.bus_error;
    assign irq_out   = res_reg.irq_out;

endmodule

// ===== design/dbcr_checker.sv =====
module dbcr_checker
    import dbcr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] read_data,
    input logic        bus_error,
    input logic        irq_out
);

    // Reset empties the result stage at once
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // A stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(bus_error)
            && $stable(irq_out))
        else $error("stalled result changed");

    // The producer is held only while the result stage is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // An errored access returns zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_error |-> read_data == 32'h0)
        else $error("bus error with nonzero read data");

endmodule

bind desktop_bus_controller_registers_unit dbcr_checker u_dbcr_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dbcr_pkg::*;

    // Cycles with no transfer on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Hold-off after the last result before the run ends.
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_PER_PHASE = 306;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_READ;
    logic [1:0]  access_size = SIZE_LONG;
    logic [7:0]  address = '0;
    logic [31:0] write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic        bus_error;
    logic        irq_out;

    // Idle/stall odds in percent, changed per traffic phase.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    int error_count = 0;
    int access_count = 0;
    int directed_count = 0;
    int result_count = 0;
    int stuck_cycles = 0;

    // Register file as the testbench believes it to be.
    logic [31:0] irq_pending = '0;
    logic [31:0] irq_enable = '0;
    logic [31:0] config_shadow = '0;
    logic [31:0] command_shadow = '0;
    logic [31:0] bit_count_shadow = '0;
    logic [31:0] data_shadow [2] = '{32'h0, 32'h0};
    logic [7:0]  status_shadow = '0;
    logic        irq_line = 1'b0;

    // Results still owed by the block, oldest first.
    dbcr_result_t pending_results[$];
    dbcr_result_t oldest;

    desktop_bus_controller_registers_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .access_size (access_size),
        .address     (address),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .bus_error   (bus_error),
        .irq_out     (irq_out)
    );

    always #5 clk = ~clk;

    // Latch new interrupt bits; the line goes up only when a new bit is enabled.
    function automatic void raise_irq(input logic [31:0] bits);
        irq_pending |= bits;
        if ((bits & irq_enable) != 0)
            irq_line = 1'b1;
    endfunction

    // Long-read decode; returns 0 for addresses that are not readable.
    function automatic logic lookup_register(input logic [7:0] addr,
                                             output logic [31:0] value);
        value = '0;
        lookup_register = 1'b1;
        case (addr)
            ADDR_INT_STATUS: value = irq_pending;
            ADDR_INT_MASK:   value = irq_enable;
            ADDR_CONFIG:     value = config_shadow;
            ADDR_STATUS:     value = {24'h0, status_shadow};
            ADDR_COMMAND:    value = command_shadow;
            ADDR_BIT_COUNT:  value = bit_count_shadow;
            ADDR_DATA0:      value = data_shadow[0];
            ADDR_DATA1:      value = data_shadow[1];
            default:         lookup_register = 1'b0;
        endcase
    endfunction

    // Apply one bus access to the shadow registers and return what the block owes.
    function automatic dbcr_result_t predict_access(input dbcr_access_t acc);
        dbcr_result_t res;
        logic [31:0]  full;
        logic [31:0]  wd;
        logic [4:0]   lane_shift;
        logic         hit;
        res = '0;
        full = '0;
        wd = acc.write_data;
        hit = 1'b1;
        if (acc.access_size == SIZE_ILLEGAL)
        begin
            hit = 1'b0;
        end
        else if (acc.opcode == OP_WRITE)
        begin
            // Only long writes reach the register file.
            if (acc.access_size != SIZE_LONG)
            begin
                hit = 1'b0;
            end
            else
            begin
                case (acc.address)
                    ADDR_INT_STATUS:
                    begin
                        irq_pending &= ~wd;
                        if ((irq_pending & irq_enable) == 0)
                            irq_line = 1'b0;
                    end
                    ADDR_INT_MASK:
                    begin
                        irq_enable = wd;
                        irq_line = |(irq_pending & irq_enable);
                    end
                    ADDR_SET_INT:
                    begin
                        irq_pending |= wd;
                        if ((irq_pending & irq_enable) != 0)
                            irq_line = 1'b1;
                    end
                    ADDR_CONFIG:    config_shadow = wd;
                    ADDR_COMMAND:   command_shadow = wd;
                    ADDR_BIT_COUNT: bit_count_shadow = wd;
                    ADDR_DATA0:     data_shadow[0] = wd;
                    ADDR_DATA1:     data_shadow[1] = wd;
                    ADDR_CONTROL:
                    begin
                        // Reset, transmit, disable, enable: in that order.
                        if (wd[CTL_RESET_BIT])
                        begin
                            status_shadow &= ~ST_POLL_EN;
                            raise_irq(INT_RESET);
                        end
                        if (wd[CTL_XMIT_BIT])
                        begin
                            if ((status_shadow & (ST_RESET | ST_ACCESS)) != 0)
                            begin
                                raise_irq(INT_REJECT);
                            end
                            else
                            begin
                                status_shadow |= ST_TIMEOUT;
                                raise_irq(INT_ACCESS);
                            end
                        end
                        if (wd[CTL_DIS_POLL_BIT])
                            status_shadow &= ~ST_POLL_EN;
                        if (wd[CTL_EN_POLL_BIT])
                        begin
                            if ((status_shadow & (ST_RESET | ST_ACCESS)) != 0 &&
                                (status_shadow & ST_POLL_EN) == 0)
                                raise_irq(INT_REJECT);
                            else
                                status_shadow |= ST_POLL_EN;
                        end
                    end
                    default: hit = 1'b0;
                endcase
            end
        end
        else if (acc.access_size == SIZE_LONG)
        begin
            hit = lookup_register(acc.address, full);
            res.read_data = full;
        end
        else
        begin
            // Narrow reads decode the aligned long and pick a big-endian lane.
            hit = lookup_register({acc.address[7:2], 2'b00}, full);
            if (acc.access_size == SIZE_WORD)
            begin
                res.read_data = acc.address[1] ? {16'h0, full[15:0]} : {16'h0, full[31:16]};
            end
            else
            begin
                lane_shift = {~acc.address[1:0], 3'b000};
                res.read_data = (full >> lane_shift) & 32'hFF;
            end
        end
        if (!hit)
            res.read_data = '0;
        res.bus_error = ~hit;
        res.irq_out = irq_line;
        return res;
    endfunction

    // Offer one access, hold it until the block takes it, then log what it owes.
    task automatic send_access(input logic op, input logic [1:0] size,
                               input logic [7:0] addr, input logic [31:0] wd);
        dbcr_access_t acc;
        acc.opcode = op;
        acc.access_size = size;
        acc.address = addr;
        acc.write_data = wd;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        access_size <= size;
        address <= addr;
        write_data <= wd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_access(acc));
        access_count++;
    endtask

    function automatic logic [7:0] decoded_address(input int index);
        case (index)
            0:       return ADDR_INT_STATUS;
            1:       return ADDR_INT_MASK;
            2:       return ADDR_SET_INT;
            3:       return ADDR_CONFIG;
            4:       return ADDR_CONTROL;
            5:       return ADDR_STATUS;
            6:       return ADDR_COMMAND;
            7:       return ADDR_BIT_COUNT;
            8:       return ADDR_DATA0;
            default: return ADDR_DATA1;
        endcase
    endfunction

    // Stall the result side at the current phase's rate.
    always @(posedge clk)
        out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);

    // Compare every result transfer with the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no access outstanding");
                error_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (read_data !== oldest.read_data)
                begin
                    $error("read_data expected %h got %h", oldest.read_data, read_data);
                    error_count++;
                end
                if (bus_error !== oldest.bus_error)
                begin
                    $error("bus_error expected %b got %b", oldest.bus_error, bus_error);
                    error_count++;
                end
                if (irq_out !== oldest.irq_out)
                begin
                    $error("irq_out expected %b got %b", oldest.irq_out, irq_out);
                    error_count++;
                end
            end
        end
    end

    // Drop the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("desktop_bus_controller_registers_unit verification failed");
            $finish;
        end
    end

    // Interrupt status reads back as zero straight out of reset.
    task automatic test_reset_state();
        send_access(OP_READ, SIZE_LONG, ADDR_INT_STATUS, 32'h0);
    endtask

    // Long writes with all-ones, all-zeros and a lane pattern, then read back the first two.
    task automatic test_long_registers();
        send_access(OP_WRITE, SIZE_LONG, ADDR_DATA0, 32'hFFFF_FFFF);
        send_access(OP_WRITE, SIZE_LONG, ADDR_DATA1, 32'h0000_0000);
        send_access(OP_WRITE, SIZE_LONG, ADDR_CONFIG, 32'h1234_5678);
        send_access(OP_READ, SIZE_LONG, ADDR_DATA0, 32'h0);
        send_access(OP_READ, SIZE_LONG, ADDR_DATA1, 32'hFFFF_FFFF);
    endtask

    // Every byte lane and both word halves of the pattern in config.
    task automatic test_narrow_reads();
        for (int lane = 0; lane < 4; lane++)
            send_access(OP_READ, SIZE_BYTE, ADDR_CONFIG | 8'(lane), 32'h0);
        send_access(OP_READ, SIZE_WORD, ADDR_CONFIG, 32'h0);
        send_access(OP_READ, SIZE_WORD, ADDR_CONFIG | 8'h02, 32'h0);
    endtask

    // Narrow writes, size code 3, unaligned long, write-only read,
    // read-only write and a hole in the map must all flag a bus error.
    task automatic test_bus_errors();
        send_access(OP_WRITE, SIZE_BYTE, ADDR_CONFIG, 32'hFFFF_FFFF);
        send_access(OP_WRITE, SIZE_WORD, ADDR_DATA0, 32'h0);
        send_access(OP_READ, SIZE_ILLEGAL, ADDR_CONFIG, 32'h0);
        send_access(OP_READ, SIZE_LONG, ADDR_CONFIG | 8'h01, 32'h0);
        send_access(OP_READ, SIZE_LONG, ADDR_SET_INT, 32'h0);
        send_access(OP_WRITE, SIZE_LONG, ADDR_STATUS, 32'hFFFF_FFFF);
        send_access(OP_READ, SIZE_LONG, 8'hFF, 32'h0);
    endtask

    // Unmask, fire every control action at once and read the status, then set, clear and mask off.
    task automatic test_interrupts();
        send_access(OP_WRITE, SIZE_LONG, ADDR_INT_MASK, INT_REJECT | INT_ACCESS | INT_RESET);
        send_access(OP_WRITE, SIZE_LONG, ADDR_CONTROL, 32'h0000_000F);
        send_access(OP_READ, SIZE_LONG, ADDR_STATUS, 32'h0);
        send_access(OP_WRITE, SIZE_LONG, ADDR_SET_INT, 32'h8000_0000);
        send_access(OP_WRITE, SIZE_LONG, ADDR_INT_STATUS, 32'hFFFF_FFFF);
        send_access(OP_WRITE, SIZE_LONG, ADDR_INT_MASK, 32'h0);
    endtask

    // Mostly decoded long accesses and lane reads, with some raw noise.
    task automatic run_random_traffic(input int count);
        int          pick;
        logic [7:0]  addr;
        logic [31:0] wd;
        for (int i = 0; i < count; i++)
        begin
            pick = int'($urandom_range(99));
            addr = decoded_address(int'($urandom_range(9)));
            wd = $urandom();
            // Keep interrupt-related writes small half the time so bits build up.
            if ((addr == ADDR_CONTROL || addr == ADDR_SET_INT ||
                 addr == ADDR_INT_STATUS || addr == ADDR_INT_MASK) && $urandom_range(1))
                wd = 32'($urandom_range(15));
            if (pick < 40)
                send_access(OP_WRITE, SIZE_LONG, addr, wd);
            else if (pick < 70)
                send_access(OP_READ, SIZE_LONG, addr, wd);
            else if (pick < 85)
                send_access(OP_READ, 2'($urandom_range(1)), addr | 8'($urandom_range(3)), wd);
            else
                send_access(1'($urandom_range(1)), 2'($urandom_range(3)),
                            8'($urandom_range(255)), wd);
        end
    endtask

    // Four traffic phases: clean, sender gaps, receiver stalls, both.
    task automatic test_random_traffic();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        run_random_traffic(RANDOM_PER_PHASE);
        sender_idle_pct = 50;
        run_random_traffic(RANDOM_PER_PHASE);
        sender_idle_pct = 0;
        receiver_stall_pct = 50;
        run_random_traffic(RANDOM_PER_PHASE);
        sender_idle_pct = 19;
        receiver_stall_pct = 19;
        run_random_traffic(RANDOM_PER_PHASE);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_long_registers();
        test_narrow_reads();
        test_bus_errors();
        test_interrupts();
        directed_count = access_count;
        test_random_traffic();

        // Release the input and let the pipeline drain; the watchdog bounds this.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d bus accesses (%0d directed, rest random over four idle/stall mixes)",
                 access_count, directed_count);
        $display("Checked %0d result transfers, %0d mismatches", result_count, error_count);
        if (error_count == 0)
            $display("desktop_bus_controller_registers_unit verification clean");
        else
            $display("desktop_bus_controller_registers_unit verification failed");
        $finish;
    end

endmodule
